// ===== design/ipu_pkg.sv =====
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared widths, codes and the copy-job record of the integer pixel upscaler.
// ----------------------------------------------------------------------------
package ipu_pkg;

	localparam int SCALE_W = 7;   // scale_factor register width
	localparam int WIDTH_W = 11;  // source_width register width
	localparam int ROWS_W  = 6;   // pending replay rows, also copies minus one
	localparam int COMP_W  = 8;   // one color component
	localparam int PIX_W   = 3 * COMP_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = WIDTH_W;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_SCALE = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

	localparam logic CMD_PIXEL  = 1'b0;
	localparam logic CMD_REPLAY = 1'b1;

	// One unit of work for the copy generator
	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic              row_end;
		logic              idle;
		logic [1:0]        pad;
		logic [ROWS_W-1:0] copies_m1;
	} ipu_job_t;

endpackage

// ===== design/ipu_line_ram.sv =====
// ----------------------------------------------------------------------------
// ipu_line_ram
// One-row pixel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipu_line_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/ipu_copy_gen.sv =====
// ----------------------------------------------------------------------------
// ipu_copy_gen
// Emits a job's copies, one per cycle while out_ready is high, from registers.
// ----------------------------------------------------------------------------
module ipu_copy_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  ipu_pkg::ipu_job_t           job,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ipu_pkg::COMP_W-1:0]  out_blue,
	output logic [ipu_pkg::COMP_W-1:0]  out_green,
	output logic [ipu_pkg::COMP_W-1:0]  out_red,
	output logic                        last_copy,
	output logic                        row_end,
	output logic [1:0]                  pad_bytes,
	output logic                        replay_idle
);
	import ipu_pkg::*;

	logic              busy_q;
	ipu_job_t          job_q;
	logic [ROWS_W-1:0] cnt_q;
	logic              final_q;
	logic              out_acc;

	assign final_q   = (cnt_q == '0);
	assign out_acc   = busy_q && out_ready;
	assign job_ready = !busy_q || (out_acc && final_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (job_valid && job_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= job.copies_m1;
		end else if (out_acc) begin
			if (final_q) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
	end

	assign out_valid   = busy_q;
	assign out_blue    = job_q.pix[COMP_W-1:0];
	assign out_green   = job_q.pix[2*COMP_W-1:COMP_W];
	assign out_red     = job_q.pix[3*COMP_W-1:2*COMP_W];
	assign last_copy   = final_q && !job_q.idle;
	assign row_end     = final_q && !job_q.idle && job_q.row_end;
	assign pad_bytes   = row_end ? job_q.pad : 2'd0;
	assign replay_idle = job_q.idle;

endmodule

// ===== design/integer_pixel_upscaler_top.sv =====
// ----------------------------------------------------------------------------
// integer_pixel_upscaler_top
// Nearest-neighbor integer upscaler for 24-bit RGB rows with row padding.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | cmd, blue, green, red
//  out     | out_valid/out_ready  | out_blue, out_green, out_red, last_copy,
//          |                      | row_end, pad_bytes, replay_idle
//
// An accepted item is decoded and its line store access issued in the accept
// cycle; the job lands in stage 1 in the next cycle, then in the copy generator,
// which sends one copy per cycle while out_ready is high. An item yields s_eff
// copies (one for an idle replay); the copy generator sets the rate. The first
// copy passes stage 1 and the job register. Stage 1 holds one waiting item while
// copies drain; with one copy per item a new item is taken every cycle while
// out_ready is high, otherwise the input stalls until the final copy of the
// current job goes out. Reset clears the column counters, pending rows and
// valids; the line store is not cleared. cfg_ready is always high.
//
module integer_pixel_upscaler_top #(
	parameter int MAX_WIDTH = ipu_pkg::DEF_MAX_WIDTH,
	parameter int MAX_SCALE = ipu_pkg::DEF_MAX_SCALE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [ipu_pkg::COMP_W-1:0]     blue,
	input  logic [ipu_pkg::COMP_W-1:0]     green,
	input  logic [ipu_pkg::COMP_W-1:0]     red,
	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ipu_pkg::COMP_W-1:0]     out_blue,
	output logic [ipu_pkg::COMP_W-1:0]     out_green,
	output logic [ipu_pkg::COMP_W-1:0]     out_red,
	output logic                           last_copy,
	output logic                           row_end,
	output logic [1:0]                     pad_bytes,
	output logic                           replay_idle
);
	import ipu_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [WIDTH_W-1:0] width_q;

	// row tracking
	logic [CW-1:0]     fill_col_q;
	logic [CW-1:0]     replay_col_q;
	logic [ROWS_W-1:0] rows_left_q;

	// stage 1
	logic              valid_s1;
	logic              replay_s1;
	logic              idle_s1;
	logic              end_s1;
	logic [PIX_W-1:0]  pix_s1;

	logic [SCALE_W-1:0] s_eff;
	logic [WIDTH_W-1:0] w_eff;
	logic [ROWS_W-1:0]  s_m1;
	logic [1:0]         pad;
	logic [CW-1:0]      col_sel;
	logic               col_end;
	logic               in_acc;
	logic               replay_ok;
	logic               wr_en;
	logic [PIX_W-1:0]   rd_data;
	logic               job_ready;
	ipu_job_t           job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= WIDTH_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_WIDTH: width_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// clamp factor and width to their usable ranges
	always_comb begin
		if (scale_q == '0) begin
			s_eff = SCALE_W'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			s_eff = SCALE_W'(MAX_SCALE);
		end else begin
			s_eff = scale_q;
		end
		if (width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
	end

	assign s_m1 = ROWS_W'(s_eff - SCALE_W'(1));
	// row bytes are 3*w*s; pad to 4 works out to (w*s) mod 4
	assign pad  = 2'(w_eff[1:0] * s_eff[1:0]);

	assign in_ready  = !valid_s1 || job_ready;
	assign in_acc    = in_valid && in_ready;
	assign replay_ok = (cmd == CMD_REPLAY) && (rows_left_q != '0);
	assign col_sel   = (cmd == CMD_REPLAY) ? replay_col_q : fill_col_q;
	// column at or past the width (after a width change) also ends the row
	assign col_end   = (32'(col_sel) + 32'd1) >= 32'(w_eff);
	assign wr_en     = in_acc && (cmd == CMD_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_col_q   <= '0;
			replay_col_q <= '0;
			rows_left_q  <= '0;
		end else if (in_acc) begin
			if (cmd == CMD_PIXEL) begin
				if (col_end) begin
					fill_col_q   <= '0;
					replay_col_q <= '0;
					rows_left_q  <= s_m1;
				end else begin
					fill_col_q <= col_sel + 1'b1;
				end
			end else if (replay_ok) begin
				if (col_end) begin
					replay_col_q <= '0;
					rows_left_q  <= rows_left_q - 1'b1;
				end else begin
					replay_col_q <= col_sel + 1'b1;
				end
			end
		end
	end

	ipu_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (PIX_W)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_col_q),
		.wr_data ({red, green, blue}),
		.rd_en   (in_acc && replay_ok),
		.rd_addr (replay_col_q),
		.rd_data (rd_data)
	);

	// stage 1: holds the decoded item; replay pixel arrives from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			replay_s1 <= (cmd == CMD_REPLAY);
			idle_s1   <= (cmd == CMD_REPLAY) && !replay_ok;
			end_s1    <= col_end;
			pix_s1    <= {red, green, blue};
		end
	end

	always_comb begin
		job.pix       = idle_s1 ? '0 : (replay_s1 ? rd_data : pix_s1);
		job.row_end   = end_s1;
		job.idle      = idle_s1;
		job.pad       = pad;
		job.copies_m1 = idle_s1 ? '0 : s_m1;
	end

	ipu_copy_gen u_copy_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (valid_s1),
		.job_ready   (job_ready),
		.job         (job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.last_copy   (last_copy),
		.row_end     (row_end),
		.pad_bytes   (pad_bytes),
		.replay_idle (replay_idle)
	);

endmodule
